/* design/rhcb_pkg.sv */
package rhcb_pkg;

	localparam int unsigned HashWidth = 32;
	localparam int unsigned PosWidth = 64;
	localparam int unsigned BitsWidth = 5;
	localparam logic [BitsWidth-1:0] BitsReset = 5'd14;

	// One input request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	// One result
	typedef struct packed {
		logic [PosWidth-1:0] boundary_position;
		logic                is_final;
	} result_t;

	// mult^n modulo 2^32, evaluated at elaboration
	function automatic logic [HashWidth-1:0] window_power(
		input logic [HashWidth-1:0] mult,
		input int unsigned          n
	);
		logic [HashWidth-1:0] acc;
		acc = 32'd1;
		for (int unsigned i = 0; i < n; i++) begin
			acc = HashWidth'(acc * mult);
		end
		return acc;
	endfunction

endpackage

/* design/rhcb_cell.sv */
// One byte of the sliding window; loads its neighbor's byte on a shift.
module rhcb_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] byte_in,
	output logic [7:0] byte_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

/* design/rhcb_hash.sv */
// Rolling hash register: hash*M + new - oldest*M^W, plus the boundary test
// on the updated value.
module rhcb_hash #(
	parameter int unsigned WINDOW_BYTES    = 31,
	parameter int unsigned HASH_MULTIPLIER = 139
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift,
	input  logic [7:0]                         new_byte,
	input  logic [7:0]                         oldest_byte,
	input  logic [rhcb_pkg::BitsWidth-1:0]     boundary_bits,
	output logic                               hit
);

	localparam logic [rhcb_pkg::HashWidth-1:0] MultK =
		rhcb_pkg::HashWidth'(HASH_MULTIPLIER);
	localparam logic [rhcb_pkg::HashWidth-1:0] PowK =
		rhcb_pkg::window_power(MultK, WINDOW_BYTES);

	logic [rhcb_pkg::HashWidth-1:0] hash_q;
	logic [rhcb_pkg::HashWidth-1:0] scaled;
	logic [rhcb_pkg::HashWidth-1:0] dropped;
	logic [rhcb_pkg::HashWidth-1:0] hash_next;
	logic [rhcb_pkg::HashWidth-1:0] mask;

	// Both products in parallel, then one add/subtract
	assign scaled    = rhcb_pkg::HashWidth'(hash_q * MultK);
	assign dropped   = rhcb_pkg::HashWidth'({24'd0, oldest_byte} * PowK);
	assign hash_next = scaled + {24'd0, new_byte} - dropped;

	// Low boundary_bits all ones; zero bits gives an empty mask
	assign mask = (rhcb_pkg::HashWidth'(1) << boundary_bits) - rhcb_pkg::HashWidth'(1);
	assign hit  = (hash_next & mask) == mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (shift) begin
			hash_q <= hash_next;
		end
	end

endmodule

/* design/rolling_hash_chunk_boundary.sv */
// Content-defined chunk boundary detector. Bytes arrive on the item channel,
// one per cycle at full rate unless the output stalls; each data byte shifts a
// WINDOW_BYTES-long row of byte cells and updates a 32-bit rolling hash
// (multiplier HASH_MULTIPLIER, modulo 2^32), so the hash multiply-add feedback
// in rhcb_hash sets the one-byte-per-cycle rate. When the low boundary_bits of
// the new hash are all ones, the 64-bit byte count (including that byte) is
// returned with is_final low. An end_of_stream request returns the count with
// is_final high; afterwards every request is accepted and dropped until reset.
// Results sit in one output register; a new byte is taken in the same cycle the
// previous result is taken. boundary_bits resets to 14; the user writes it on
// the cfg channel only while the block is idle; the block does not enforce it.
module rolling_hash_chunk_boundary #(
	parameter int unsigned WINDOW_BYTES    = 31,
	parameter int unsigned HASH_MULTIPLIER = 139
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  rhcb_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output rhcb_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rhcb_pkg::BitsWidth-1:0]     cfg_data
);

	logic [rhcb_pkg::BitsWidth-1:0] bits_q;
	logic [rhcb_pkg::PosWidth-1:0]  position_q;
	logic                           stream_done_q;
	logic                           result_valid_q;
	rhcb_pkg::result_t              result_q;
	logic                           accept;
	logic                           data_go;
	logic                           eos_go;
	logic                           hit;
	logic [rhcb_pkg::PosWidth-1:0]  position_next;
	logic [7:0]                     window [WINDOW_BYTES];

	assign cfg_ready    = 1'b1;
	assign item_ready   = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign accept        = item_valid && item_ready;
	assign data_go       = accept && !stream_done_q && !item.end_of_stream;
	assign eos_go        = accept && !stream_done_q && item.end_of_stream;
	assign position_next = position_q + rhcb_pkg::PosWidth'(1);

	// Window cells: cell 0 is the oldest byte, the last cell takes the new byte
	for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_cell
		logic [7:0] feed;
		if (g == WINDOW_BYTES - 1) begin : g_tail
			assign feed = item.data_byte;
		end else begin : g_body
			assign feed = window[g+1];
		end
		rhcb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (data_go),
			.byte_in (feed),
			.byte_q  (window[g])
		);
	end

	rhcb_hash #(
		.WINDOW_BYTES    (WINDOW_BYTES),
		.HASH_MULTIPLIER (HASH_MULTIPLIER)
	) u_hash (
		.clk           (clk),
		.arst_n        (arst_n),
		.shift         (data_go),
		.new_byte      (item.data_byte),
		.oldest_byte   (window[0]),
		.boundary_bits (bits_q),
		.hit           (hit)
	);

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= rhcb_pkg::BitsReset;
		end else if (cfg_valid && cfg_ready) begin
			bits_q <= cfg_data;
		end
	end

	// Position counter and end-of-stream flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			stream_done_q <= 1'b0;
		end else begin
			if (data_go) begin
				position_q <= position_next;
			end
			if (eos_go) begin
				stream_done_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			priority if (eos_go || (data_go && hit)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end else begin
				result_valid_q <= result_valid_q;
			end
		end
	end

	// eos_go and data_go never coincide
	always_ff @(posedge clk) begin
		if (eos_go) begin
			result_q.boundary_position <= position_q;
			result_q.is_final          <= 1'b1;
		end else if (data_go && hit) begin
			result_q.boundary_position <= position_next;
			result_q.is_final          <= 1'b0;
		end
	end

	// A pending boundary result always carries the current byte count
	a_boundary_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.is_final |-> result_q.boundary_position == position_q)
		else $error("boundary result position differs from byte count");

	// A final result implies the stream is closed
	a_final_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.is_final |-> stream_done_q)
		else $error("final result without end of stream");

	// Nothing new appears once the stream is closed and drained
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		stream_done_q && !result_valid_q |=> !result_valid_q)
		else $error("result after end of stream");

	// Counter moves only by a data byte
	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		!data_go |=> position_q == $past(position_q))
		else $error("byte count changed without a data byte");

endmodule
